// ===== src/sbsh_pkg.sv =====
package sbsh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] round;
    } round_ctrl_t;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // index 0 is H0
    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== src/sbsh_wmem.sv =====
module sbsh_wmem (
    input  logic             clk,
    input  logic             we,
    input  logic [3:0]       waddr,
    input  sbsh_pkg::word_t  wdata,
    input  logic [3:0]       raddr_a,
    input  logic [3:0]       raddr_b,
    output sbsh_pkg::word_t  rdata_a,
    output sbsh_pkg::word_t  rdata_b
);
    import sbsh_pkg::*;

    word_t mem [16];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/sbsh_round.sv =====
module sbsh_round (
    input  logic                  clk,
    input  sbsh_pkg::round_ctrl_t ctrl,
    input  sbsh_pkg::word_t       rd_a,
    input  sbsh_pkg::word_t       rd_b,
    input  sbsh_pkg::hash_t       h_in,
    output sbsh_pkg::word_t       w_out,
    output sbsh_pkg::hash_t       v_out
);
    import sbsh_pkg::*;

    hash_t v_reg;
    hash_t v_next;
    word_t w1_reg;
    word_t w2_reg;
    word_t a_prev_reg;
    word_t w_sched;
    word_t w;
    word_t t1;
    word_t t2;

    // rd_b: message word in the first sixteen rounds, W[t-7] after;
    // rd_a: W[t-15], and its previous value is W[t-16]
    always_comb
    begin
        w_sched = small_sigma1(w2_reg) + rd_b + small_sigma0(rd_a) + a_prev_reg;
        w       = (ctrl.round[5:4] == 2'b00) ? rd_b : w_sched;
        t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
           + ROUND_K[ctrl.round] + w;
        t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= h_in;
        end
        else if (ctrl.step)
        begin
            v_reg      <= v_next;
            w1_reg     <= w;
            w2_reg     <= w1_reg;
            a_prev_reg <= rd_a;
        end
    end

    assign w_out = w;
    assign v_out = v_reg;

endmodule

// ===== src/sha256_byte_stream_hasher_unit.sv =====
// Append: a byte is taken whenever the block is idle; every 64th byte adds a compression
// (load, 64 rounds at one per cycle through the schedule memory, final add).
// Bytes are taken only in the idle state, never during a compression; one round unit does all rounds.
// Finish: padding words, one or two compressions, then 8 output transfers.
// Reset (asynchronous, active low) loads the initial hash and empties the buffer;
// the word memory is not cleared.
module sha256_byte_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // message_byte
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);
    import sbsh_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_PRE  = 6'b000100,
        S_RND  = 6'b001000,
        S_ADD  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic [23:0] acc_reg, acc_next;
    hash_t       h_reg, h_next;
    logic [3:0]  widx_reg, widx_next;
    logic        long_reg, long_next;
    logic        fin_reg, fin_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  oidx_reg, oidx_next;

    logic        mem_we;
    logic [3:0]  mem_waddr;
    word_t       mem_wdata;
    logic [3:0]  raddr_a;
    logic [3:0]  raddr_b;
    word_t       rdata_a;
    word_t       rdata_b;
    round_ctrl_t ctrl;
    word_t       w_out;
    hash_t       v_out;
    word_t       pad_word;
    word_t       pad_fill;
    logic [63:0] bit_len;

    sbsh_wmem u_wmem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    sbsh_round u_round (
        .clk   (clk),
        .ctrl  (ctrl),
        .rd_a  (rdata_a),
        .rd_b  (rdata_b),
        .h_in  (h_reg),
        .w_out (w_out),
        .v_out (v_out)
    );

    assign bit_len = {count_reg[60:0], 3'b000};

    // partial word closed by the pad byte, remaining bytes zero
    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'h0};
            2'd1: pad_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2: pad_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
            2'd3: pad_word = {acc_reg[23:0], PAD_BYTE};
            default: pad_word = '0;
        endcase
    end

    always_comb
    begin
        if (!long_reg && widx_reg == 4'd14)
        begin
            pad_fill = bit_len[63:32];
        end
        else if (!long_reg && widx_reg == 4'd15)
        begin
            pad_fill = bit_len[31:0];
        end
        else
        begin
            pad_fill = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        h_next     = h_reg;
        widx_next  = widx_reg;
        long_next  = long_reg;
        fin_next   = fin_reg;
        round_next = round_reg;
        oidx_next  = oidx_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        raddr_a    = '0;
        raddr_b    = '0;
        ctrl       = '0;
        ctrl.round = round_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == ACT_FINISH)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = fill_reg[5:2];
                        mem_wdata = pad_word;
                        fin_next  = 1'b1;
                        if (fill_reg[5:2] == 4'd15)
                        begin
                            // pad byte closes the block: length goes in a second one
                            long_next  = 1'b1;
                            state_next = S_PRE;
                        end
                        else
                        begin
                            widx_next  = fill_reg[5:2] + 4'd1;
                            long_next  = (fill_reg[5:2] == 4'd14);
                            state_next = S_PAD;
                        end
                    end
                    else
                    begin
                        acc_next   = {acc_reg[15:0], s_tdata};
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 64'd1;
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = fill_reg[5:2];
                            mem_wdata = {acc_reg, s_tdata};
                        end
                        if (fill_reg == 6'd63)
                        begin
                            state_next = S_PRE;
                        end
                    end
                end
            end
            S_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = widx_reg;
                mem_wdata = pad_fill;
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'd15)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                raddr_a    = 4'd1;
                raddr_b    = 4'd0;
                ctrl.load  = 1'b1;
                round_next = '0;
                state_next = S_RND;
            end
            S_RND:
            begin
                ctrl.step = 1'b1;
                // prefetch for the next round
                raddr_a = round_reg[3:0] + 4'd2;
                raddr_b = (round_reg < 6'd15) ? round_reg[3:0] + 4'd1
                                              : round_reg[3:0] + 4'd10;
                if (round_reg[5:4] != 2'b00)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = round_reg[3:0];
                    mem_wdata = w_out;
                end
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + v_out[i];
                end
                if (fin_reg && long_reg)
                begin
                    long_next  = 1'b0;
                    widx_next  = '0;
                    state_next = S_PAD;
                end
                else if (fin_reg)
                begin
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        h_next     = INIT_HASH;
                        fill_next  = '0;
                        count_next = '0;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tdata = h_reg[oidx_reg];
    assign m_tuser = oidx_reg;
    assign m_tlast = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            h_reg     <= INIT_HASH;
            widx_reg  <= '0;
            long_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            h_reg     <= h_next;
            widx_reg  <= widx_next;
            long_reg  <= long_next;
            fin_reg   <= fin_next;
            round_reg <= round_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while digest is pending");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_reg == 6'd0))
        else $error("block did not restart after last digest word");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RND && round_reg == 6'd63) |=> state_reg == S_ADD)
        else $error("compression did not end after round 63");

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest words out of order");
`endif

endmodule
